>>> rtl/ptrs_pkg.sv
// shared types and constants for the periodic task release scanner
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned DEND_W  = TICK_W + 1;
  localparam int unsigned STEP_W  = $clog2(DEND_W);
  localparam int unsigned ID_W    = 3;
  localparam int unsigned SCAN_W  = ID_W + 1;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned MOD_RST = 1000;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CIDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FIRST   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LAST    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CHECK,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic write_entry;
    logic start_tick;
    logic commit_tick;
    logic start_check;
    logic hit;
    logic advance;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic entry_ok;
    logic scan_end;
  } dp_status_t;

endpackage

>>> rtl/ptrs_rem.sv
// restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module ptrs_rem import ptrs_pkg::*; #(
  parameter int unsigned DIV_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEND_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DEND_W-1:0] num_q, num_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[DEND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(DEND_W - 1);
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // partial remainder stays below the divisor, so one subtract suffices
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      num_d = {num_q[DEND_W-2:0], 1'b0};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/ptrs_datapath.sv
// config registers, thread table, tick counter, scan pointer and result registers
`timescale 1ns / 1ps

module ptrs_datapath import ptrs_pkg::*; #(
  parameter int unsigned THREAD_COUNT = 8,
  parameter int unsigned PERIOD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic [ID_W-1:0]   entry_id_i,
  input  logic              entry_active_i,
  input  logic [TICK_W-1:0] entry_period_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_status_t        status_o,
  output logic              strobe_o,
  output logic              due_o,
  output logic [ID_W-1:0]   due_thread_o,
  output logic [TICK_W-1:0] tick_value_o,
  output logic              last_o
);

  // ids at or above THREAD_COUNT never reach the table, which holds at most eight entries
  localparam int unsigned TblDepth = (THREAD_COUNT < 8) ? THREAD_COUNT : 8;
  localparam int unsigned TblIdxW  = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam int unsigned DivW     = (PERIOD_BITS > DEND_W) ? PERIOD_BITS : DEND_W;

  logic [TICK_W-1:0]      modulus_q;
  logic [ID_W-1:0]        first_q;
  logic [ID_W-1:0]        last_q;
  logic [TICK_W-1:0]      counter_q;
  logic [SCAN_W-1:0]      scan_q;
  logic                   pend_valid_q;
  logic [ID_W-1:0]        pend_id_q;
  logic                   active_q [TblDepth];
  logic [PERIOD_BITS-1:0] period_q [TblDepth];

  logic                   strobe_q, strobe_d;
  logic                   due_q, due_d;
  logic [ID_W-1:0]        thread_q, thread_d;
  logic                   beat_last_q, beat_last_d;

  logic [TblIdxW-1:0]     wr_idx;
  logic [TblIdxW-1:0]     rd_idx;
  logic                   sel_active;
  logic [PERIOD_BITS-1:0] sel_period;
  logic [DEND_W-1:0]      modulus_ext;
  logic [DEND_W-1:0]      div_dividend;
  logic [DivW-1:0]        div_divisor;
  logic                   div_done;
  logic [DivW-1:0]        div_rem;

  assign wr_idx     = entry_id_i[TblIdxW-1:0];
  assign rd_idx     = scan_q[TblIdxW-1:0];
  assign sel_active = active_q[rd_idx];
  assign sel_period = period_q[rd_idx];

  // a zero modulus lets the counter wrap freely in 16 bits
  assign modulus_ext = (modulus_q == '0) ? (DEND_W'(1) << TICK_W) : {1'b0, modulus_q};

  always_comb begin
    if (cmd_i.start_tick) begin
      div_dividend = {1'b0, counter_q} + DEND_W'(1);
      div_divisor  = DivW'(modulus_ext);
    end else begin
      div_dividend = {1'b0, counter_q};
      div_divisor  = DivW'(sel_period);
    end
  end

  ptrs_rem #(
    .DIV_W(DivW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start_tick | cmd_i.start_check),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  assign status_o.div_done = div_done;
  assign status_o.rem_zero = (div_rem == '0);
  assign status_o.entry_ok = (32'(scan_q) < THREAD_COUNT) && sel_active &&
                             (sel_period != '0);
  assign status_o.scan_end = (scan_q > {1'b0, last_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= TICK_W'(MOD_RST);
      first_q   <= '0;
      last_q    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODULUS: modulus_q <= cfg_wdata_i[TICK_W-1:0];
        CFG_FIRST:   first_q   <= cfg_wdata_i[ID_W-1:0];
        CFG_LAST:    last_q    <= cfg_wdata_i[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TblDepth; i++) begin
        active_q[i] <= 1'b0;
        period_q[i] <= '0;
      end
    end else if (cmd_i.write_entry && (32'(entry_id_i) < THREAD_COUNT)) begin
      active_q[wr_idx] <= entry_active_i;
      period_q[wr_idx] <= PERIOD_BITS'(entry_period_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q    <= '0;
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_id_q    <= '0;
    end else begin
      if (cmd_i.commit_tick) begin
        counter_q <= div_rem[TICK_W-1:0];
      end
      if (cmd_i.start_tick) begin
        scan_q       <= {1'b0, first_q};
        pend_valid_q <= 1'b0;
      end else if (cmd_i.advance) begin
        scan_q <= scan_q + SCAN_W'(1);
      end
      // a due thread is held back until we know whether it is the final beat
      if (cmd_i.hit) begin
        pend_valid_q <= 1'b1;
        pend_id_q    <= scan_q[ID_W-1:0];
      end
    end
  end

  always_comb begin
    strobe_d    = 1'b0;
    due_d       = due_q;
    thread_d    = thread_q;
    beat_last_d = beat_last_q;
    if (cmd_i.hit && pend_valid_q) begin
      strobe_d    = 1'b1;
      due_d       = 1'b1;
      thread_d    = pend_id_q;
      beat_last_d = 1'b0;
    end else if (cmd_i.finish) begin
      strobe_d    = 1'b1;
      due_d       = pend_valid_q;
      thread_d    = pend_valid_q ? pend_id_q : '0;
      beat_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q       <= due_d;
    thread_q    <= thread_d;
    beat_last_q <= beat_last_d;
  end

  assign strobe_o     = strobe_q;
  assign due_o        = due_q;
  assign due_thread_o = thread_q;
  assign tick_value_o = counter_q;
  assign last_o       = beat_last_q;

endmodule

>>> rtl/ptrs_ctrl.sv
// sequencing state machine for tick counting and the thread scan
`timescale 1ns / 1ps

module ptrs_ctrl import ptrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       op_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (op_i == OP_WRITE) begin
            cmd_o.write_entry = 1'b1;
          end else begin
            cmd_o.start_tick = 1'b1;
            state_d          = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (status_i.div_done) begin
          cmd_o.commit_tick = 1'b1;
          state_d           = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.scan_end) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.entry_ok) begin
          cmd_o.start_check = 1'b1;
          state_d           = ST_WAIT;
        end else begin
          // inactive, not periodic or outside the table
          cmd_o.advance = 1'b1;
        end
      end
      ST_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.hit     = status_i.rem_zero;
          cmd_o.advance = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

>>> rtl/periodic_task_release_scan.sv
// top level of the periodic task release scanner
// Usage:
//   An item is taken on a clock edge with start_i high and busy_o low.
//   op_i = 1 writes one thread table entry (entry_id_i, entry_active_i,
//   entry_period_i) in that same edge and gives no result; busy_o stays low.
//   op_i = 0 is a timer tick: the counter advances modulo counter_modulus,
//   then ids first_thread..last_thread are scanned in ascending order.
//   Each due thread gives one result beat with strobe_o high for one cycle;
//   a tick with no due thread gives one beat with due_o low. last_o marks
//   the final beat of a tick. The receiver cannot stall; beats are never held.
//   The counter update runs in the shared remainder unit (17 remainder
//   steps, one dividend bit each) and is then committed. Each scanned
//   thread that is active with a nonzero period takes one more pass
//   through the remainder unit, every other scanned id is skipped
//   without one, and a closing step ends the scan and gives the last beat.
//   One tick is worked on at a time; busy_o is low again in the cycle that
//   carries the last beat, so the next item can be taken at its end.
//   Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once
//   and must be made while busy_o is low; the block does not enforce this.
//   Reset clears the counter and the table, loads modulus 1000, range 0..7.
`timescale 1ns / 1ps

module periodic_task_release_scan import ptrs_pkg::*; #(
  parameter int unsigned THREAD_COUNT = 8,
  parameter int unsigned PERIOD_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              op_i,
  input  logic [ID_W-1:0]   entry_id_i,
  input  logic              entry_active_i,
  input  logic [TICK_W-1:0] entry_period_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output logic              strobe_o,
  output logic              due_o,
  output logic [ID_W-1:0]   due_thread_o,
  output logic [TICK_W-1:0] tick_value_o,
  output logic              last_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ptrs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ptrs_datapath #(
    .THREAD_COUNT(THREAD_COUNT),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_id_i    (entry_id_i),
    .entry_active_i(entry_active_i),
    .entry_period_i(entry_period_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .strobe_o      (strobe_o),
    .due_o         (due_o),
    .due_thread_o  (due_thread_o),
    .tick_value_o  (tick_value_o),
    .last_o        (last_o)
  );

  // a beat with no due thread always closes its tick
  a_nodue_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !due_o |-> last_o)
    else $error("no-due beat without last mark");

  // the closing beat of a tick is never followed directly by another beat
  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("beat right after the final beat of a tick");

  // an accepted tick keeps the block busy on the next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (op_i == OP_TICK) |=> busy_o)
    else $error("tick accepted but block not busy");

  // an idle cycle cannot produce a beat on the following cycle
  a_idle_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !strobe_o)
    else $error("beat emitted without a tick in progress");

endmodule

>>> test/testbench.sv
// self-checking testbench for the periodic task release scanner
`timescale 1ns / 1ps

module testbench;
  import ptrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic              due;
    logic [ID_W-1:0]   thread;
    logic [TICK_W-1:0] tick;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   id;
    logic              act;
    logic [TICK_W-1:0] per;
    logic              typed;
    beat_t             want;
  } stim_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              op_i;
  logic [ID_W-1:0]   entry_id_i;
  logic              entry_active_i;
  logic [TICK_W-1:0] entry_period_i;
  logic              cfg_we_i;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              strobe_o;
  logic              due_o;
  logic [ID_W-1:0]   due_thread_o;
  logic [TICK_W-1:0] tick_value_o;
  logic              last_o;

  // shadow of the block state and its registers
  logic [TICK_W-1:0] tick_count = '0;
  logic              thread_on [8];
  logic [TICK_W-1:0] thread_period [8];
  logic [TICK_W-1:0] wrap_modulus = TICK_W'(MOD_RST);
  logic [ID_W-1:0]   scan_first = '0;
  logic [ID_W-1:0]   scan_last = 3'd7;

  beat_t released [8];
  beat_t pending_releases [$];
  int    mismatches = 0;
  int    cycles = 0;

  stim_t plan [18] = '{
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, '{1'b0, 3'd0, 16'd1, 1'b1}},
    '{OP_WRITE, 3'd0, 1'b1, 16'h0001, 1'b0, '0},
    '{OP_WRITE, 3'd7, 1'b1, 16'hFFFF, 1'b0, '0},
    '{OP_WRITE, 3'd3, 1'b0, 16'h0002, 1'b0, '0},
    '{OP_WRITE, 3'd5, 1'b1, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 3'd2, 1'b1, 16'h0002, 1'b0, '0},
    '{OP_WRITE, 3'd4, 1'b1, 16'h8000, 1'b0, '0},
    '{OP_WRITE, 3'd6, 1'b1, 16'h0003, 1'b0, '0},
    '{OP_WRITE, 3'd1, 1'b0, 16'h7FFF, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0},
    '{OP_WRITE, 3'd0, 1'b0, 16'h0001, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b1, '{1'b0, 3'd0, 16'd7, 1'b1}},
    '{OP_WRITE, 3'd3, 1'b1, 16'h0002, 1'b0, '0},
    '{OP_TICK,  3'd0, 1'b0, 16'h0000, 1'b0, '0}
  };

  periodic_task_release_scan dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .entry_id_i     (entry_id_i),
    .entry_active_i (entry_active_i),
    .entry_period_i (entry_period_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .strobe_o       (strobe_o),
    .due_o          (due_o),
    .due_thread_o   (due_thread_o),
    .tick_value_o   (tick_value_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // advances the tick counter and fills released[] with this tick's beats
  function automatic int release_scan();
    int unsigned wrap;
    int n;
    wrap = (wrap_modulus == '0) ? 65536 : int'(wrap_modulus);
    tick_count = TICK_W'((int'(tick_count) + 1) % wrap);
    n = 0;
    for (int id = scan_first; id <= scan_last; id++) begin
      if (thread_on[id] && thread_period[id] != '0 && tick_count % thread_period[id] == '0) begin
        released[n] = '{1'b1, ID_W'(id), tick_count, 1'b0};
        n++;
      end
    end
    if (n == 0) begin
      released[0] = '{1'b0, '0, tick_count, 1'b1};
      n = 1;
    end else begin
      released[n-1].last = 1'b1;
    end
    return n;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // every result beat is checked against the oldest expected release
  always @(posedge clk_i) begin
    beat_t exp_beat;
    if (strobe_o === 1'b1) begin
      if (pending_releases.size() == 0) begin
        mismatches++;
        $display("%0t: expected no beat, got due=%0d thread=%0d tick=%0d last=%0d",
                 $time, due_o, due_thread_o, tick_value_o, last_o);
      end else begin
        exp_beat = pending_releases.pop_front();
        if (due_o !== exp_beat.due || due_thread_o !== exp_beat.thread ||
            tick_value_o !== exp_beat.tick || last_o !== exp_beat.last) begin
          mismatches++;
          $display("%0t: expected due=%0d thread=%0d tick=%0d last=%0d, got %0d %0d %0d %0d",
                   $time, exp_beat.due, exp_beat.thread, exp_beat.tick, exp_beat.last,
                   due_o, due_thread_o, tick_value_o, last_o);
        end
      end
    end
  end

  task automatic offer(input stim_t s);
    int n;
    start_i        <= 1'b1;
    op_i           <= s.op;
    entry_id_i     <= s.id;
    entry_active_i <= s.act;
    entry_period_i <= s.per;
    do @(posedge clk_i); while (busy_o);
    if (s.op == OP_WRITE) begin
      thread_on[s.id]     = s.act;
      thread_period[s.id] = s.per;
    end else begin
      n = release_scan();
      if (s.typed) begin
        pending_releases.push_back(s.want);
      end else begin
        for (int k = 0; k < n; k++) pending_releases.push_back(released[k]);
      end
    end
  endtask

  task automatic pause(input int gap);
    start_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // drop start and let every outstanding release come back
  task automatic settle();
    start_i <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODULUS: wrap_modulus = data;
      CFG_FIRST:   scan_first = data[ID_W-1:0];
      CFG_LAST:    scan_last = data[ID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] modulus, input logic [ID_W-1:0] first,
                           input logic [ID_W-1:0] last, input int count);
    stim_t item;
    int burst_left;
    settle();
    set_reg(CFG_UNUSED, CFG_W'($urandom));
    set_reg(CFG_MODULUS, modulus);
    set_reg(CFG_FIRST, {13'($urandom), first});
    set_reg(CFG_LAST, {13'($urandom), last});
    cfg_we_i <= 1'b0;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      item.op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_TICK;
      item.id = ID_W'($urandom_range(0, 7));
      item.act = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0:       item.per = '0;
        1:       item.per = TICK_W'($urandom);
        2, 3:    item.per = TICK_W'($urandom_range(9, 64));
        default: item.per = TICK_W'($urandom_range(1, 8));
      endcase
      item.typed = 1'b0;
      item.want = '0;
      offer(item);
      if (burst_left == 0) begin
        pause($urandom_range(1, $urandom_range(0, 1) ? 6 : 60));
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      thread_on[i] = 1'b0;
      thread_period[i] = '0;
    end
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    op_i           <= OP_TICK;
    entry_id_i     <= '0;
    entry_active_i <= 1'b0;
    entry_period_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_MODULUS;
    cfg_wdata_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < 18; r++) begin
      offer(plan[r]);
      if (r % 5 == 4) pause($urandom_range(1, 8));
    end

    // counter above a freshly lowered modulus, then a modulus of one
    run_phase(16'd5, 3'd0, 3'd7, 18);
    run_phase(16'd1, 3'd0, 3'd7, 18);
    // zero modulus wraps freely in 16 bits
    run_phase(16'd0, 3'd0, 3'd7, 18);
    run_phase(16'd65535, 3'd3, 3'd5, 18);
    // empty scan range
    run_phase(16'd100, 3'd6, 3'd2, 18);
    run_phase(16'd1000, 3'd7, 3'd7, 18);
    run_phase(16'd7, 3'd0, 3'd0, 18);
    run_phase(16'd12, 3'd0, 3'd7, 18);

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_releases.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ptrs_pkg.sv
rtl/ptrs_rem.sv
rtl/ptrs_datapath.sv
rtl/ptrs_ctrl.sv
rtl/periodic_task_release_scan.sv
test/testbench.sv
